/* sv/tbpr_pkg.sv */
// ----------------------------------------------------------------------------
// tbpr_pkg: shared types and constants of the background pixel renderer
// Request formats, register indexes, memory geometry and the shade lookup.
// ----------------------------------------------------------------------------
package tbpr_pkg;

  // Screen and memory geometry.
  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 144;
  localparam int VRAM_BYTES    = 8192;
  localparam int VRAM_AW       = $clog2(VRAM_BYTES);
  localparam int BANK_DEPTH    = VRAM_BYTES / 2;
  localparam int BANK_AW       = $clog2(BANK_DEPTH);

  // Tile map and pattern base addresses.
  localparam logic [VRAM_AW-1:0] MAP_LOW_BASE     = 13'h1800;
  localparam logic [VRAM_AW-1:0] MAP_HIGH_BASE    = 13'h1C00;
  localparam logic [VRAM_AW-1:0] SIGNED_TILE_BASE = 13'h1000;

  // Output queue sizing.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Request operations.
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_LCD_ENABLE   = 3'd0,
    CFG_UNSIGNED_MODE = 3'd1,
    CFG_BG_MAP_HIGH  = 3'd2,
    CFG_SCROLL_X     = 3'd3,
    CFG_SCROLL_Y     = 3'd4,
    CFG_BG_PALETTE   = 3'd5
  } cfg_idx_t;

  // Input request payload.
  typedef struct packed {
    logic               op;
    logic [VRAM_AW-1:0] vram_address;
    logic [7:0]         write_data;
    logic [7:0]         pixel_x;
    logic [7:0]         line;
  } pix_in_t;

  // Result payload.
  typedef struct packed {
    logic [7:0] out_column;
    logic [7:0] out_row;
    logic [7:0] shade;
  } pix_out_t;

  // Write port of one memory bank.
  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] idx;
    logic [7:0]         data;
  } bank_wr_t;

  // Map a 2-bit color through the palette to a gray level.
  function automatic logic [7:0] shade_of(input logic [7:0] palette,
                                          input logic [1:0] color);
    logic [1:0] sel;
    logic [7:0] gray;
    case (color)
      2'd0:    sel = palette[1:0];
      2'd1:    sel = palette[3:2];
      2'd2:    sel = palette[5:4];
      default: sel = palette[7:6];
    endcase
    case (sel)
      2'd0:    gray = 8'h00;
      2'd1:    gray = 8'h3F;
      2'd2:    gray = 8'h7E;
      default: gray = 8'hFF;
    endcase
    return gray;
  endfunction

endpackage

/* sv/tile_background_pixel_renderer_core.sv */
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer_core: background tile pixel renderer
// Holds video memory, takes byte writes and renders background pixels.
// ----------------------------------------------------------------------------
// After reset the block clears its 8 KiB video memory, two bytes per cycle;
// in_stall stays high during that pass while configuration writes are still
// taken. After that it accepts one request per cycle while the result queue
// has room. A write request stores its byte on the edge it is accepted and
// is seen by any pixel request accepted later. A pixel request goes through
// two registered memory reads before it is written into the result queue:
// the tile map is read on the accepting edge, both bytes of the tile
// row are read on the next edge (the memory is split into even and odd banks,
// each with two read ports), and in the cycle after that the color is picked
// and the shade looked up as the pixel is written into the queue. A
// four-entry result queue decouples the consumer; requests are held off only
// when the queue plus the pixels in flight already fill it.
module tile_background_pixel_renderer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tbpr_pkg::pix_in_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tbpr_pkg::pix_out_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  // Configuration registers.
  logic       lcd_enable_r;
  logic       unsigned_mode_r;
  logic       bg_map_high_r;
  logic [7:0] scroll_x_r;
  logic [7:0] scroll_y_r;
  logic [7:0] bg_palette_r;

  // Memory clear sequencer.
  logic                         clearing_r;
  logic                         clearing_nxt;
  logic [tbpr_pkg::BANK_AW-1:0] clr_idx_r;
  logic [tbpr_pkg::BANK_AW-1:0] clr_idx_nxt;

  // Request decode.
  logic                         in_accept;
  logic                         do_write;
  logic                         do_render;
  logic [7:0]                   xa;
  logic [7:0]                   ya;
  logic [tbpr_pkg::VRAM_AW-1:0] map_addr;

  // Stage after the map read.
  logic       s1_v_r;
  logic [7:0] s1_col_r;
  logic [7:0] s1_row_r;
  logic [2:0] s1_fine_x_r;
  logic [2:0] s1_fine_y_r;
  logic       s1_odd_r;

  // Stage after the pattern read.
  logic       s2_v_r;
  logic [7:0] s2_col_r;
  logic [7:0] s2_row_r;
  logic [2:0] s2_fine_x_r;

  // Memory connections.
  tbpr_pkg::bank_wr_t           even_wr;
  tbpr_pkg::bank_wr_t           odd_wr;
  logic [7:0]                   even_a_data;
  logic [7:0]                   odd_a_data;
  logic [7:0]                   even_b_data;
  logic [7:0]                   odd_b_data;
  logic [7:0]                   tile;
  logic [tbpr_pkg::VRAM_AW-1:0] tile_base;
  logic [tbpr_pkg::VRAM_AW-1:0] row_addr;

  // Shading and output.
  logic [2:0]                   bit_sel;
  logic [1:0]                   color;
  tbpr_pkg::pix_out_t           result;
  logic [tbpr_pkg::OQ_CW-1:0]   q_count;
  logic [tbpr_pkg::OQ_CW-1:0]   in_flight;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_enable_r    <= 1'b0;
      unsigned_mode_r <= 1'b0;
      bg_map_high_r   <= 1'b0;
      scroll_x_r      <= '0;
      scroll_y_r      <= '0;
      bg_palette_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tbpr_pkg::CFG_LCD_ENABLE:    lcd_enable_r    <= cfg_wdata[0];
        tbpr_pkg::CFG_UNSIGNED_MODE: unsigned_mode_r <= cfg_wdata[0];
        tbpr_pkg::CFG_BG_MAP_HIGH:   bg_map_high_r   <= cfg_wdata[0];
        tbpr_pkg::CFG_SCROLL_X:      scroll_x_r      <= cfg_wdata;
        tbpr_pkg::CFG_SCROLL_Y:      scroll_y_r      <= cfg_wdata;
        tbpr_pkg::CFG_BG_PALETTE:    bg_palette_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Clear pass over both banks, one row of each per cycle.
  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == '1) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // Admission: leave room in the queue for every pixel still in flight.
  assign in_flight = q_count + tbpr_pkg::OQ_CW'(s1_v_r) + tbpr_pkg::OQ_CW'(s2_v_r);
  assign in_stall  = clearing_r || (in_flight >= tbpr_pkg::OQ_CW'(tbpr_pkg::OQ_DEPTH));
  assign in_accept = in_valid && !in_stall;

  // Decode the request; only visible pixels with the display on go on.
  assign do_write  = in_accept && (in_data.op == tbpr_pkg::OP_WRITE);
  assign do_render = in_accept && (in_data.op == tbpr_pkg::OP_RENDER) && lcd_enable_r
                     && ({1'b0, in_data.line} < 9'(tbpr_pkg::SCREEN_HEIGHT))
                     && ({1'b0, in_data.pixel_x} < 9'(tbpr_pkg::SCREEN_WIDTH));

  // Scrolled coordinates wrap at 256; the map entry follows from them.
  assign xa       = in_data.pixel_x + scroll_x_r;
  assign ya       = in_data.line + scroll_y_r;
  assign map_addr = (bg_map_high_r ? tbpr_pkg::MAP_HIGH_BASE : tbpr_pkg::MAP_LOW_BASE)
                    | {3'b000, ya[7:3], xa[7:3]};

  // Bank writes: the clear pass or a write request, by address parity.
  always_comb begin
    if (clearing_r) begin
      even_wr = '{en: 1'b1, idx: clr_idx_r, data: 8'h00};
      odd_wr  = '{en: 1'b1, idx: clr_idx_r, data: 8'h00};
    end else begin
      even_wr = '{en: do_write && !in_data.vram_address[0],
                  idx: in_data.vram_address[tbpr_pkg::VRAM_AW-1:1],
                  data: in_data.write_data};
      odd_wr  = '{en: do_write && in_data.vram_address[0],
                  idx: in_data.vram_address[tbpr_pkg::VRAM_AW-1:1],
                  data: in_data.write_data};
    end
  end

  // Tile row address from the map entry, signed or unsigned numbering.
  assign tile      = s1_odd_r ? odd_a_data : even_a_data;
  assign tile_base = unsigned_mode_r ? {1'b0, tile, 4'b0000}
                                     : tbpr_pkg::SIGNED_TILE_BASE + {tile[7], tile, 4'b0000};
  assign row_addr  = tile_base | {9'b0, s1_fine_y_r, 1'b0};

  tbpr_bank u_even (
    .clk       (clk),
    .wr        (even_wr),
    .rd_a_idx  (map_addr[tbpr_pkg::VRAM_AW-1:1]),
    .rd_a_data (even_a_data),
    .rd_b_idx  (row_addr[tbpr_pkg::VRAM_AW-1:1]),
    .rd_b_data (even_b_data)
  );

  tbpr_bank u_odd (
    .clk       (clk),
    .wr        (odd_wr),
    .rd_a_idx  (map_addr[tbpr_pkg::VRAM_AW-1:1]),
    .rd_a_data (odd_a_data),
    .rd_b_idx  (row_addr[tbpr_pkg::VRAM_AW-1:1]),
    .rd_b_data (odd_b_data)
  );

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= do_render;
      s2_v_r <= s1_v_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    s1_col_r    <= in_data.pixel_x;
    s1_row_r    <= in_data.line;
    s1_fine_x_r <= xa[2:0];
    s1_fine_y_r <= ya[2:0];
    s1_odd_r    <= map_addr[0];
    s2_col_r    <= s1_col_r;
    s2_row_r    <= s1_row_r;
    s2_fine_x_r <= s1_fine_x_r;
  end

  // Leftmost pixel sits in bit 7 of each pattern byte.
  assign bit_sel = 3'd7 - s2_fine_x_r;
  assign color   = {odd_b_data[bit_sel], even_b_data[bit_sel]};
  assign result  = '{out_column: s2_col_r,
                     out_row:    s2_row_r,
                     shade:      tbpr_pkg::shade_of(bg_palette_r, color)};

  tbpr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_v_r),
    .push_data (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_count)
  );

  // The pixel pipeline never holds: a map read is always followed by a pattern read.
  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("pixel pipeline lost a request");

  // Queue space covers every pixel in flight.
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight <= tbpr_pkg::OQ_CW'(tbpr_pkg::OQ_DEPTH))
    else $error("pixels in flight exceed result queue space");

  // No pixel is in flight while the memory is being cleared.
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!s1_v_r && !s2_v_r && !out_valid))
    else $error("pixel activity during the clear pass");

endmodule

/* sv/tbpr_bank.sv */
// ----------------------------------------------------------------------------
// tbpr_bank: one half of the video memory
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tbpr_bank (
  input  logic                          clk,
  input  tbpr_pkg::bank_wr_t            wr,
  input  logic [tbpr_pkg::BANK_AW-1:0]  rd_a_idx,
  output logic [7:0]                    rd_a_data,
  input  logic [tbpr_pkg::BANK_AW-1:0]  rd_b_idx,
  output logic [7:0]                    rd_b_data
);

  logic [7:0] mem_r [tbpr_pkg::BANK_DEPTH];
  logic [7:0] rd_a_data_r;
  logic [7:0] rd_b_data_r;

  // Reads return the contents from before a write on the same edge.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.idx] <= wr.data;
    end
    rd_a_data_r <= mem_r[rd_a_idx];
    rd_b_data_r <= mem_r[rd_b_idx];
  end

  assign rd_a_data = rd_a_data_r;
  assign rd_b_data = rd_b_data_r;

endmodule

/* sv/tbpr_outq.sv */
// ----------------------------------------------------------------------------
// tbpr_outq: result queue
// Small queue that holds finished pixels until the consumer takes them.
// ----------------------------------------------------------------------------
module tbpr_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  tbpr_pkg::pix_out_t           push_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tbpr_pkg::pix_out_t           out_data,
  output logic [tbpr_pkg::OQ_CW-1:0]   count
);

  tbpr_pkg::pix_out_t              entries_r [tbpr_pkg::OQ_DEPTH];
  logic [tbpr_pkg::OQ_AW-1:0]      wr_ptr_r;
  logic [tbpr_pkg::OQ_AW-1:0]      wr_ptr_nxt;
  logic [tbpr_pkg::OQ_AW-1:0]      rd_ptr_r;
  logic [tbpr_pkg::OQ_AW-1:0]      rd_ptr_nxt;
  logic [tbpr_pkg::OQ_CW-1:0]      count_r;
  logic [tbpr_pkg::OQ_CW-1:0]      count_nxt;
  logic                            pop;

  assign pop = out_valid && !out_stall;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = (count_r != '0);
  assign out_data  = entries_r[rd_ptr_r];
  assign count     = count_r;

  // A push never lands on a full queue unless an entry leaves on the same edge.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && (count_r == tbpr_pkg::OQ_CW'(tbpr_pkg::OQ_DEPTH))))
    else $error("result queue overflow");

  // Occupancy tracks the pointer distance.
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[tbpr_pkg::OQ_AW-1:0])
    else $error("result queue pointers and count disagree");

endmodule

/* tb/tile_background_pixel_renderer_core_tb.sv */
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer_core_tb: self-checking bench of the renderer
// Drives video memory writes and pixel requests through the valid/stall
// channel, keeps a shadow copy of video memory and of the view registers,
// predicts every background pixel and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_background_pixel_renderer_core_tb;

  // Unused register indexes; writes to them must change nothing.
  localparam logic [2:0] CFG_SPARE_LOW  = 3'd6;
  localparam logic [2:0] CFG_SPARE_HIGH = 3'd7;

  // Timing of the bench.
  localparam int PIPE_SETTLE_CYCLES = 8;
  localparam int END_DRAIN_CYCLES   = 12;
  localparam int HOLD_CYCLES        = 300;
  localparam int WATCHDOG_LIMIT     = 20000;
  localparam int IDLE_PERCENT       = 25;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  tbpr_pkg::pix_in_t  in_data;
  logic               out_valid;
  logic               out_stall;
  tbpr_pkg::pix_out_t out_data;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [7:0]         cfg_wdata;

  // Shadow of the block's state.
  logic [7:0] vram_copy [tbpr_pkg::VRAM_BYTES];
  logic       lcd_on;
  logic       unsigned_tiles;
  logic       map_high;
  logic [7:0] view_scroll_x;
  logic [7:0] view_scroll_y;
  logic [7:0] view_palette;

  // Pixels predicted and not yet seen at the output.
  tbpr_pkg::pix_out_t pending_pixels [$];

  int  mismatches;
  bit  tx_idle_en;
  bit  rx_idle_en;
  int  hold_requests;

  tile_background_pixel_renderer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Background gray level of one screen pixel under the current view.
  function automatic logic [7:0] expected_shade(input logic [7:0] col,
                                                input logic [7:0] row);
    logic [7:0]                   xa;
    logic [7:0]                   ya;
    logic [7:0]                   tile;
    logic [7:0]                   lo_byte;
    logic [7:0]                   hi_byte;
    logic [tbpr_pkg::VRAM_AW-1:0] map_addr;
    logic [tbpr_pkg::VRAM_AW-1:0] row_addr;
    logic [2:0]                   bit_pos;
    logic [1:0]                   color;
    logic [1:0]                   level;
    logic [7:0]                   gray;
    xa = col + view_scroll_x;
    ya = row + view_scroll_y;
    map_addr = (map_high ? tbpr_pkg::MAP_HIGH_BASE : tbpr_pkg::MAP_LOW_BASE)
               + {3'b000, ya[7:3], xa[7:3]};
    tile = vram_copy[map_addr];
    // Signed tile numbers are offsets around the middle of the pattern area.
    if (unsigned_tiles) begin
      row_addr = {1'b0, tile, 4'b0000};
    end else begin
      row_addr = tbpr_pkg::SIGNED_TILE_BASE + {tile[7], tile, 4'b0000};
    end
    row_addr = row_addr + {ya[2:0], 1'b0};
    bit_pos = 3'd7 - xa[2:0];
    lo_byte = vram_copy[row_addr];
    hi_byte = vram_copy[row_addr + 13'd1];
    color = {hi_byte[bit_pos], lo_byte[bit_pos]};
    case (color)
      2'd0:    level = view_palette[1:0];
      2'd1:    level = view_palette[3:2];
      2'd2:    level = view_palette[5:4];
      default: level = view_palette[7:6];
    endcase
    case (level)
      2'd0:    gray = 8'h00;
      2'd1:    gray = 8'h3F;
      2'd2:    gray = 8'h7E;
      default: gray = 8'hFF;
    endcase
    return gray;
  endfunction

  // Apply an accepted request to the shadow state.
  task automatic record_request(input tbpr_pkg::pix_in_t req);
    tbpr_pkg::pix_out_t px;
    if (req.op == tbpr_pkg::OP_WRITE) begin
      vram_copy[req.vram_address] = req.write_data;
    end else if (lcd_on && req.line < tbpr_pkg::SCREEN_HEIGHT
                 && req.pixel_x < tbpr_pkg::SCREEN_WIDTH) begin
      px.out_column = req.pixel_x;
      px.out_row    = req.line;
      px.shade      = expected_shade(req.pixel_x, req.line);
      pending_pixels.push_back(px);
    end
  endtask

  // Offer one request; entered and left at a falling edge.
  task automatic send_request(input tbpr_pkg::pix_in_t req);
    while (tx_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_request(req);
    @(negedge clk);
  endtask

  task automatic store_byte(input logic [tbpr_pkg::VRAM_AW-1:0] addr,
                            input logic [7:0] data);
    tbpr_pkg::pix_in_t req;
    req.op           = tbpr_pkg::OP_WRITE;
    req.vram_address = addr;
    req.write_data   = data;
    req.pixel_x      = 8'($urandom);
    req.line         = 8'($urandom);
    send_request(req);
  endtask

  task automatic request_pixel(input logic [7:0] col, input logic [7:0] row);
    tbpr_pkg::pix_in_t req;
    req.op           = tbpr_pkg::OP_RENDER;
    req.vram_address = tbpr_pkg::VRAM_AW'($urandom);
    req.write_data   = 8'($urandom);
    req.pixel_x      = col;
    req.line         = row;
    send_request(req);
  endtask

  // Stop offering requests, wait for every pixel, then let the pipe empty.
  task automatic settle_block(input int extra);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // One register write; the shadow follows the same decode.
  task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tbpr_pkg::CFG_LCD_ENABLE:    lcd_on         = value[0];
      tbpr_pkg::CFG_UNSIGNED_MODE: unsigned_tiles = value[0];
      tbpr_pkg::CFG_BG_MAP_HIGH:   map_high       = value[0];
      tbpr_pkg::CFG_SCROLL_X:      view_scroll_x  = value;
      tbpr_pkg::CFG_SCROLL_Y:      view_scroll_y  = value;
      tbpr_pkg::CFG_BG_PALETTE:    view_palette   = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Reprogram the whole view once the block has gone quiet.
  task automatic set_view(input logic lcd, input logic uns, input logic high,
                          input logic [7:0] sx, input logic [7:0] sy,
                          input logic [7:0] pal);
    settle_block(PIPE_SETTLE_CYCLES);
    write_register(tbpr_pkg::CFG_LCD_ENABLE, {7'($urandom), lcd});
    write_register(tbpr_pkg::CFG_UNSIGNED_MODE, {7'($urandom), uns});
    write_register(tbpr_pkg::CFG_BG_MAP_HIGH, {7'($urandom), high});
    write_register(tbpr_pkg::CFG_SCROLL_X, sx);
    write_register(tbpr_pkg::CFG_SCROLL_Y, sy);
    write_register(tbpr_pkg::CFG_BG_PALETTE, pal);
  endtask

  // Tile numbers that the random writes keep coming back to.
  function automatic logic [7:0] favored_tile();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(8'h00, 8'h07));
      1:       return 8'($urandom_range(8'h7C, 8'h83));
      default: return 8'($urandom_range(8'hF8, 8'hFF));
    endcase
  endfunction

  // Random request aimed at the maps and patterns that pixels actually read.
  function automatic tbpr_pkg::pix_in_t random_request();
    tbpr_pkg::pix_in_t req;
    int                pick;
    logic [7:0]        tile;
    req.vram_address = tbpr_pkg::VRAM_AW'($urandom);
    req.write_data   = 8'($urandom);
    req.pixel_x      = 8'($urandom);
    req.line         = 8'($urandom);
    if ($urandom_range(0, 99) < 35) begin
      req.op = tbpr_pkg::OP_WRITE;
      pick = $urandom_range(0, 9);
      tile = favored_tile();
      if (pick < 4) begin
        req.vram_address = ($urandom_range(0, 1) ? tbpr_pkg::MAP_HIGH_BASE
                                                 : tbpr_pkg::MAP_LOW_BASE)
                           + tbpr_pkg::VRAM_AW'($urandom_range(0, 1023));
        req.write_data = favored_tile();
      end else if (pick < 6) begin
        req.vram_address = {1'b0, tile, 4'b0000}
                           + tbpr_pkg::VRAM_AW'($urandom_range(0, 15));
      end else if (pick < 8) begin
        req.vram_address = tbpr_pkg::SIGNED_TILE_BASE + {tile[7], tile, 4'b0000}
                           + tbpr_pkg::VRAM_AW'($urandom_range(0, 15));
      end
    end else begin
      req.op = tbpr_pkg::OP_RENDER;
      if ($urandom_range(0, 9) != 0) begin
        req.pixel_x = 8'($urandom_range(0, tbpr_pkg::SCREEN_WIDTH - 1));
      end
      if ($urandom_range(0, 9) != 0) begin
        req.line = 8'($urandom_range(0, tbpr_pkg::SCREEN_HEIGHT - 1));
      end
    end
    return req;
  endfunction

  task automatic send_random_requests(input int count);
    repeat (count) send_request(random_request());
  endtask

  // Register writes during the memory clearing pass, spare indexes included.
  task automatic test_register_writes();
    write_register(CFG_SPARE_LOW, 8'hFF);
    write_register(CFG_SPARE_HIGH, 8'hFF);
    set_view(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    write_register(CFG_SPARE_LOW, 8'h00);
    set_view(1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'hE4);
  endtask

  // Field extremes, screen edges, scroll wrap and both tile modes.
  task automatic test_directed_cases();
    // Cleared memory renders color zero everywhere.
    request_pixel(8'd0, 8'd0);
    store_byte(13'h1800, 8'h01);
    store_byte(13'h0010, 8'hA5);
    store_byte(13'h0011, 8'h3C);
    store_byte(13'h1FFF, 8'hFF);
    request_pixel(8'd0, 8'd0);
    request_pixel(8'd7, 8'd0);
    request_pixel(8'd159, 8'd143);
    // Column and line past the screen give nothing.
    request_pixel(8'd160, 8'd10);
    request_pixel(8'd10, 8'd144);
    request_pixel(8'd255, 8'd255);
    // Signed tiles on the high map with a scroll that wraps both axes.
    set_view(1'b1, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'h1B);
    store_byte(13'h1C00, 8'h80);
    store_byte(13'h0800, 8'hFF);
    store_byte(13'h0801, 8'h0F);
    store_byte(13'h1FFF, 8'h7F);
    store_byte(13'h17FE, 8'h01);
    store_byte(13'h17FF, 8'h80);
    request_pixel(8'd1, 8'd1);
    request_pixel(8'd0, 8'd0);
    request_pixel(8'd3, 8'd1);
    request_pixel(8'd159, 8'd143);
    // Display off: writes still land, pixels give nothing.
    set_view(1'b0, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'h1B);
    request_pixel(8'd1, 8'd1);
    store_byte(13'h0802, 8'hAA);
    set_view(1'b1, 1'b0, 1'b1, 8'hFF, 8'hFE, 8'h1B);
    request_pixel(8'd1, 8'd2);
  endtask

  task automatic test_display_off();
    set_view(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom),
             8'($urandom), 8'($urandom));
    send_random_requests(20);
  endtask

  // Several views, extremes first, then random ones.
  task automatic test_random_views();
    set_view(1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    send_random_requests(110);
    set_view(1'b1, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_random_requests(110);
    set_view(1'b1, 1'b0, 1'b0, 8'h00, 8'hFF, 8'hE4);
    send_random_requests(110);
    repeat (4) begin
      set_view(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom),
               8'($urandom), 8'($urandom));
      send_random_requests(110);
    end
  endtask

  // Back-to-back traffic with neither side idling.
  task automatic test_full_rate();
    set_view(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom),
             8'($urandom), 8'hE4);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_requests(150);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_result_backpressure();
    set_view(1'b1, 1'b1, 1'b0, 8'($urandom), 8'($urandom), 8'h1B);
    tx_idle_en = 1'b0;
    hold_requests++;
    repeat (80) request_pixel(8'($urandom_range(0, tbpr_pkg::SCREEN_WIDTH - 1)),
                              8'($urandom_range(0, tbpr_pkg::SCREEN_HEIGHT - 1)));
    tx_idle_en = 1'b1;
  endtask

  // The sender pauses until every pixel has come back, then resumes.
  task automatic test_drain_pause();
    send_random_requests(20);
    settle_block(0);
    send_random_requests(20);
  endtask

  // Result side: random stall, with a long hold when one is requested.
  initial begin : result_receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_idle_en) begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Each accepted pixel against the oldest prediction.
  initial begin : result_checker
    tbpr_pkg::pix_out_t want;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel: out_column %0d out_row %0d shade %0h",
                 out_data.out_column, out_data.out_row, out_data.shade);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          if (out_data.out_column !== want.out_column) begin
            $error("out_column mismatch: expected %0d, actual %0d",
                   want.out_column, out_data.out_column);
            mismatches++;
          end
          if (out_data.out_row !== want.out_row) begin
            $error("out_row mismatch: expected %0d, actual %0d",
                   want.out_row, out_data.out_row);
            mismatches++;
          end
          if (out_data.shade !== want.shade) begin
            $error("shade mismatch: expected %0h, actual %0h", want.shade, out_data.shade);
            mismatches++;
          end
        end
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $error("no request or pixel accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("** tile_background_pixel_renderer_core: FAILED **");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    mismatches     = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    hold_requests  = 0;
    lcd_on         = 1'b0;
    unsigned_tiles = 1'b0;
    map_high       = 1'b0;
    view_scroll_x  = '0;
    view_scroll_y  = '0;
    view_palette   = '0;
    foreach (vram_copy[i]) vram_copy[i] = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_writes();
    test_directed_cases();
    test_display_off();
    test_random_views();
    test_full_rate();
    test_result_backpressure();
    test_drain_pause();

    settle_block(END_DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("** tile_background_pixel_renderer_core: PASSED **");
    end else begin
      $display("** tile_background_pixel_renderer_core: FAILED **");
    end
    $finish;
  end

endmodule
